// ===== hw/rtl/ppas_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppas_pkg
// Shared types and constants of the particle pair attraction step.
// ----------------------------------------------------------------------------
package ppas_pkg;

    // word field widths
    localparam int DATA_W     = 16;
    localparam int CFG_W      = 15;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = CFG_W;

    // shared compare/subtract unit width
    localparam int SU_W = 32;

    // iteration counts of the sqrt and divide loops
    localparam int SQRT_STEPS = 16;
    localparam int DIV_STEPS  = 10;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PULL_RANGE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_SPEED  = 1'b1;

    // register reset values
    localparam logic [CFG_W-1:0] PULL_RANGE_RST = 15'd80;
    localparam logic [CFG_W-1:0] TOP_SPEED_RST  = 15'd1280;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic [CFG_W-1:0]         cfg_val_t;
    typedef logic [SU_W-1:0]          su_t;

    typedef enum logic
    {
        FUNC_LOAD     = 1'b0,
        FUNC_INTERACT = 1'b1
    } func_t;

    typedef struct packed
    {
        cfg_val_t pull_range;
        cfg_val_t top_speed;
    } ppas_cfg_t;

    typedef struct packed
    {
        func_t func;
        data_t pos_x;
        data_t pos_y;
        data_t vel_x;
        data_t vel_y;
        data_t power;
        logic  last_partner;
    } ppas_item_t;

    typedef struct packed
    {
        data_t out_x;
        data_t out_y;
        data_t out_vx;
        data_t out_vy;
        logic  done_res;
    } ppas_result_t;

endpackage
`default_nettype wire

// ===== hw/rtl/ppas_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppas channel interfaces
// Valid/ready channels for the input word and the result word.
// ----------------------------------------------------------------------------

// input word channel
interface ppas_in_if;
    logic           valid;
    logic           ready;
    logic           func;
    ppas_pkg::data_t pos_x;
    ppas_pkg::data_t pos_y;
    ppas_pkg::data_t vel_x;
    ppas_pkg::data_t vel_y;
    ppas_pkg::data_t power;
    logic           last_partner;

    modport source
    (
        output valid, func, pos_x, pos_y, vel_x, vel_y, power, last_partner,
        input  ready
    );

    modport sink
    (
        input  valid, func, pos_x, pos_y, vel_x, vel_y, power, last_partner,
        output ready
    );
endinterface

// result word channel
interface ppas_out_if;
    logic           valid;
    logic           ready;
    ppas_pkg::data_t out_x;
    ppas_pkg::data_t out_y;
    ppas_pkg::data_t out_vx;
    ppas_pkg::data_t out_vy;
    logic           done_res;

    modport source
    (
        output valid, out_x, out_y, out_vx, out_vy, done_res,
        input  ready
    );

    modport sink
    (
        input  valid, out_x, out_y, out_vx, out_vy, done_res,
        output ready
    );
endinterface
`default_nettype wire

// ===== hw/rtl/ppas_cmpsub.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppas_cmpsub
// Shared compare/subtract unit used by the square root and divide steps.
// ----------------------------------------------------------------------------
module ppas_cmpsub
(
    input  ppas_pkg::su_t a,
    input  ppas_pkg::su_t b,
    output logic          ge,
    output ppas_pkg::su_t diff
);
    import ppas_pkg::*;

    logic [SU_W:0] wide;

    // one subtract gives both the compare and the remainder
    always_comb
    begin
        wide = {1'b0, a} - {1'b0, b};
        ge   = ~wide[SU_W];
        diff = wide[SU_W-1:0];
    end

endmodule
`default_nettype wire

// ===== hw/rtl/ppas_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppas_engine
// Particle state, sequencer and datapath: squares, iterative square root,
// iterative force divide, velocity and position update.
// ----------------------------------------------------------------------------
module ppas_engine #(
    parameter int POS_WIDTH = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  ppas_pkg::ppas_item_t   item,
    input  logic                   item_valid,
    output logic                   item_ready,
    input  ppas_pkg::ppas_cfg_t    cfg,
    output ppas_pkg::ppas_result_t res,
    output logic                   res_valid,
    input  logic                   res_ready
);
    import ppas_pkg::*;

    localparam int DW        = ((POS_WIDTH > DATA_W) ? POS_WIDTH : DATA_W) + 1;
    localparam int CNT_W     = $clog2(SQRT_STEPS);
    localparam int Q_W       = DIV_STEPS;
    localparam int FORCE_W   = Q_W + 1;
    localparam int DIV_SHIFT = 6;
    localparam int DVS_W     = DATA_W - 1 + DIV_SHIFT;
    localparam int VS_W      = DATA_W + 2;
    localparam int STEP_W    = 10;
    localparam int PROD_W    = 2 * DATA_W;

    typedef logic signed [POS_WIDTH-1:0] pos_t;
    typedef logic signed [DW-1:0]        wide_t;
    typedef logic signed [FORCE_W-1:0]   force_t;
    typedef logic signed [STEP_W-1:0]    step_t;

    localparam wide_t POS_HI = {{(DW-POS_WIDTH+1){1'b0}}, {(POS_WIDTH-1){1'b1}}};
    localparam wide_t POS_LO = {{(DW-POS_WIDTH+1){1'b1}}, {(POS_WIDTH-1){1'b0}}};
    localparam wide_t D_MAX  = {{(DW-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
    localparam wide_t D_MIN  = -D_MAX;

    typedef enum logic [10:0]
    {
        ST_IDLE  = 11'b00000000001,
        ST_MULX  = 11'b00000000010,
        ST_MULY  = 11'b00000000100,
        ST_SQRT  = 11'b00000001000,
        ST_MULPX = 11'b00000010000,
        ST_DIVX  = 11'b00000100000,
        ST_MULPY = 11'b00001000000,
        ST_DIVY  = 11'b00010000000,
        ST_UPDV  = 11'b00100000000,
        ST_UPDP  = 11'b01000000000,
        ST_EMIT  = 11'b10000000000
    } state_t;

    // saturate to the position range
    function automatic pos_t pos_sat(input wide_t v);
        if (v > POS_HI)
            return POS_HI[POS_WIDTH-1:0];
        if (v < POS_LO)
            return POS_LO[POS_WIDTH-1:0];
        return v[POS_WIDTH-1:0];
    endfunction

    // damp by one half and add the force, with rounding, then clamp to the speed limit
    function automatic data_t vel_upd(input data_t v, input force_t f, input cfg_val_t lim);
        logic signed [VS_W-1:0] s;
        logic [VS_W-1:0]        m;
        logic [VS_W-1:0]        r;
        data_t                  l;
        data_t                  rv;
        s  = (VS_W'(v) <<< 1) + VS_W'(f);
        m  = s[VS_W-1] ? VS_W'(-s) : VS_W'(s);
        r  = (m + VS_W'(2)) >> 2;
        l  = data_t'({1'b0, lim});
        rv = data_t'(r[DATA_W-1:0]);
        if (r >= VS_W'(lim))
            return s[VS_W-1] ? -l : l;
        return s[VS_W-1] ? -rv : rv;
    endfunction

    // velocity to whole position units, rounded half away from zero
    function automatic step_t pos_step(input data_t v);
        logic [DATA_W-1:0] m;
        logic [DATA_W:0]   r;
        m = v[DATA_W-1] ? DATA_W'(-v) : DATA_W'(v);
        r = ({1'b0, m} + (DATA_W+1)'(128)) >> 8;
        return v[DATA_W-1] ? -step_t'(r[STEP_W-1:0]) : step_t'(r[STEP_W-1:0]);
    endfunction

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    pos_t                 part_x_reg, part_x_next;
    pos_t                 part_y_reg, part_y_next;
    data_t                part_vx_reg, part_vx_next;
    data_t                part_vy_reg, part_vy_next;
    data_t                part_power_reg, part_power_next;
    logic                 last_reg, last_next;

    su_t                  rem_reg, rem_next;
    su_t                  root_reg, root_next;
    logic [Q_W-1:0]       q_reg, q_next;
    logic [DVS_W-1:0]     dvs_reg, dvs_next;
    logic                 fneg_reg, fneg_next;
    data_t                dx_reg, dx_next;
    data_t                dy_reg, dy_next;
    logic                 far_reg, far_next;
    force_t               fx_reg, fx_next;
    force_t               fy_reg, fy_next;

    // shared unit and multiplier wiring
    su_t                  cs_a, cs_b, cs_diff;
    logic                 cs_ge;
    data_t                ma, mb;
    logic signed [PROD_W-1:0] prod;
    su_t                  sq_bit, sq_trial, div_b, root_step;
    logic [CNT_W-1:0]     div_sh;
    logic [Q_W-1:0]       q_step;
    data_t                d_val;
    logic                 force_on;
    wide_t                dx_w, dy_w, px_w, py_w;
    logic                 accept;

    ppas_cmpsub u_cmpsub
    (
        .a    (cs_a),
        .b    (cs_b),
        .ge   (cs_ge),
        .diff (cs_diff)
    );

    assign item_ready = (state_reg == ST_IDLE);
    assign res_valid  = (state_reg == ST_EMIT);
    assign accept     = item_valid & item_ready;

    // result word from the particle state
    always_comb
    begin
        px_w         = wide_t'(part_x_reg);
        py_w         = wide_t'(part_y_reg);
        res.out_x    = px_w[DATA_W-1:0];
        res.out_y    = py_w[DATA_W-1:0];
        res.out_vx   = part_vx_reg;
        res.out_vy   = part_vy_reg;
        res.done_res = last_reg;
    end

    // partner offsets
    always_comb
    begin
        dx_w = wide_t'(part_x_reg) - wide_t'($signed(item.pos_x));
        dy_w = wide_t'(part_y_reg) - wide_t'($signed(item.pos_y));
    end

    // multiplier operand select
    always_comb
    begin
        ma = dx_reg;
        mb = dx_reg;
        unique case (state_reg)
            ST_MULY:
            begin
                ma = dy_reg;
                mb = dy_reg;
            end
            ST_MULPX:
            begin
                ma = part_power_reg;
                mb = dx_reg;
            end
            ST_MULPY:
            begin
                ma = part_power_reg;
                mb = dy_reg;
            end
            default:
            begin
                ma = dx_reg;
                mb = dx_reg;
            end
        endcase
        prod = ma * mb;
    end

    // compare/subtract operands for sqrt and divide steps
    always_comb
    begin
        sq_bit    = su_t'(1) << {~cnt_reg, 1'b0};
        sq_trial  = root_reg + sq_bit;
        div_sh    = CNT_W'(DIV_STEPS - 1) - cnt_reg;
        div_b     = su_t'(dvs_reg) << div_sh;
        cs_a      = rem_reg;
        cs_b      = (state_reg == ST_SQRT) ? sq_trial : div_b;
        root_step = cs_ge ? ((root_reg >> 1) + sq_bit) : (root_reg >> 1);
        q_step    = {q_reg[Q_W-2:0], cs_ge};
        d_val     = data_t'(root_step[DATA_W-1:0]);
        force_on  = ~far_reg && (d_val != '0)
                    && ({1'b0, d_val} < (DATA_W+1)'(cfg.pull_range));
    end

    // sequencer and datapath next state
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        part_x_next     = part_x_reg;
        part_y_next     = part_y_reg;
        part_vx_next    = part_vx_reg;
        part_vy_next    = part_vy_reg;
        part_power_next = part_power_reg;
        last_next       = last_reg;
        rem_next        = rem_reg;
        root_next       = root_reg;
        q_next          = q_reg;
        dvs_next        = dvs_reg;
        fneg_next       = fneg_reg;
        dx_next         = dx_reg;
        dy_next         = dy_reg;
        far_next        = far_reg;
        fx_next         = fx_reg;
        fy_next         = fy_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    last_next = item.last_partner;
                    if (item.func == FUNC_LOAD)
                    begin
                        part_x_next     = pos_sat(wide_t'($signed(item.pos_x)));
                        part_y_next     = pos_sat(wide_t'($signed(item.pos_y)));
                        part_vx_next    = item.vel_x;
                        part_vy_next    = item.vel_y;
                        part_power_next = item.power;
                        state_next      = ST_EMIT;
                    end
                    else
                    begin
                        dx_next    = data_t'(dx_w[DATA_W-1:0]);
                        dy_next    = data_t'(dy_w[DATA_W-1:0]);
                        far_next   = ~((dx_w >= D_MIN) && (dx_w <= D_MAX)
                                       && (dy_w >= D_MIN) && (dy_w <= D_MAX));
                        state_next = ST_MULX;
                    end
                end
            end
            ST_MULX:
            begin
                rem_next   = su_t'(prod);
                state_next = ST_MULY;
            end
            ST_MULY:
            begin
                rem_next   = rem_reg + su_t'(prod);
                root_next  = '0;
                cnt_next   = '0;
                state_next = ST_SQRT;
            end
            ST_SQRT:
            begin
                if (cs_ge)
                    rem_next = cs_diff;
                root_next = root_step;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(SQRT_STEPS - 1))
                begin
                    dvs_next = {d_val[DATA_W-2:0], {DIV_SHIFT{1'b0}}};
                    if (force_on)
                        state_next = ST_MULPX;
                    else
                    begin
                        fx_next    = '0;
                        fy_next    = '0;
                        state_next = ST_UPDV;
                    end
                end
            end
            ST_MULPX, ST_MULPY:
            begin
                fneg_next  = prod[PROD_W-1];
                rem_next   = prod[PROD_W-1] ? su_t'(-prod) : su_t'(prod);
                q_next     = '0;
                cnt_next   = '0;
                state_next = (state_reg == ST_MULPX) ? ST_DIVX : ST_DIVY;
            end
            ST_DIVX, ST_DIVY:
            begin
                if (cs_ge)
                    rem_next = cs_diff;
                q_next   = q_step;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    if (state_reg == ST_DIVX)
                    begin
                        fx_next    = fneg_reg ? -force_t'(q_step) : force_t'(q_step);
                        state_next = ST_MULPY;
                    end
                    else
                    begin
                        fy_next    = fneg_reg ? -force_t'(q_step) : force_t'(q_step);
                        state_next = ST_UPDV;
                    end
                end
            end
            ST_UPDV:
            begin
                part_vx_next = vel_upd(part_vx_reg, fx_reg, cfg.top_speed);
                part_vy_next = vel_upd(part_vy_reg, fy_reg, cfg.top_speed);
                state_next   = ST_UPDP;
            end
            ST_UPDP:
            begin
                part_x_next = pos_sat(wide_t'(part_x_reg) + wide_t'(pos_step(part_vx_reg)));
                part_y_next = pos_sat(wide_t'(part_y_reg) + wide_t'(pos_step(part_vy_reg)));
                state_next  = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (res_ready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control and particle state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            part_x_reg     <= '0;
            part_y_reg     <= '0;
            part_vx_reg    <= '0;
            part_vy_reg    <= '0;
            part_power_reg <= '0;
            last_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            part_x_reg     <= part_x_next;
            part_y_reg     <= part_y_next;
            part_vx_reg    <= part_vx_next;
            part_vy_reg    <= part_vy_next;
            part_power_reg <= part_power_next;
            last_reg       <= last_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        root_reg <= root_next;
        q_reg    <= q_next;
        dvs_reg  <= dvs_next;
        fneg_reg <= fneg_next;
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        far_reg  <= far_next;
        fx_reg   <= fx_next;
        fy_reg   <= fy_next;
    end

endmodule
`default_nettype wire

// ===== hw/rtl/particle_pair_attraction_step.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// particle_pair_attraction_step
// Holds one particle and applies pairwise attraction from partner positions.
// ----------------------------------------------------------------------------
// A load word replaces the particle state and returns it as the result word.
// In an interact word two multiplies form dx^2+dy^2, sixteen steps of the
// shared compare/subtract unit take the integer square root, then for each
// axis one multiply and ten steps of the same unit divide power*dx
// (power*dy) by 64*d, followed by a velocity update, a position update and
// the result state. When no force applies (partner outside the search
// radius or on the particle) the divides are skipped. The result word sits
// in an output register, so the next input word can start while it waits.
// The user must write the registers through the cfg port while the block
// is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module particle_pair_attraction_step #(
    parameter int POS_WIDTH = 16
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    ppas_in_if.sink                           item_ch,
    ppas_out_if.source                        result_ch,
    input  logic                              cfg_we,
    input  logic [ppas_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ppas_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import ppas_pkg::*;

    ppas_cfg_t    cfg_reg, cfg_next;
    ppas_item_t   item;
    ppas_result_t res;
    ppas_result_t out_reg, out_next;
    logic         out_valid_reg, out_valid_next;
    logic         res_valid;
    logic         res_ready;

    // input word unpack
    always_comb
    begin
        item.func         = func_t'(item_ch.func);
        item.pos_x        = item_ch.pos_x;
        item.pos_y        = item_ch.pos_y;
        item.vel_x        = item_ch.vel_x;
        item.vel_y        = item_ch.vel_y;
        item.power        = item_ch.power;
        item.last_partner = item_ch.last_partner;
    end

    ppas_engine #(
        .POS_WIDTH (POS_WIDTH)
    ) u_engine
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .item_valid (item_ch.valid),
        .item_ready (item_ch.ready),
        .cfg        (cfg_reg),
        .res        (res),
        .res_valid  (res_valid),
        .res_ready  (res_ready)
    );

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PULL_RANGE: cfg_next.pull_range = cfg_data;
                REG_TOP_SPEED:  cfg_next.top_speed  = cfg_data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    // output register
    always_comb
    begin
        res_ready      = ~out_valid_reg | result_ch.ready;
        out_valid_next = out_valid_reg & ~result_ch.ready;
        out_next       = out_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pull_range <= PULL_RANGE_RST;
            cfg_reg.top_speed  <= TOP_SPEED_RST;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    // result word drive
    assign result_ch.valid    = out_valid_reg;
    assign result_ch.out_x    = out_reg.out_x;
    assign result_ch.out_y    = out_reg.out_y;
    assign result_ch.out_vx   = out_reg.out_vx;
    assign result_ch.out_vy   = out_reg.out_vy;
    assign result_ch.done_res = out_reg.done_res;

endmodule
`default_nettype wire

// ===== test/tb_particle_pair_attraction_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_particle_pair_attraction_step
// Drives load and interact words into the particle attraction step and checks
// every returned particle word against an in-bench predictor of the position,
// velocity and force arithmetic. It covers directed edge cases, zero radius,
// zero speed limit, and random particle groups under several register
// settings. Both channels stall at random.
// ----------------------------------------------------------------------------
module tb_particle_pair_attraction_step;
    import ppas_pkg::*;

    localparam int POS_WIDTH     = 16;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_REPORTS   = 40;

    logic           clk;
    logic           rst_n;
    logic           cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    ppas_in_if  item_ch();
    ppas_out_if result_ch();

    particle_pair_attraction_step #(
        .POS_WIDTH(POS_WIDTH)
    )
    uut
    (
        .clk(clk),
        .rst_n(rst_n),
        .item_ch(item_ch),
        .result_ch(result_ch),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // predicted particle and register copies
    longint particle_x;
    longint particle_y;
    longint particle_vx;
    longint particle_vy;
    longint particle_power;
    longint radius_reg;
    longint limit_reg;

    ppas_result_t expected_particles[$];
    int           mismatches;
    int unsigned  cycle_count;
    bit           no_idle;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // cycle counter and watchdog
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count <= cycle_count + 1;
        end
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("tb_particle_pair_attraction_step: done, errors");
        $finish;
    end

    // divide by 2^k, halves away from zero
    function automatic longint half_away(input longint s, input int k);
        longint m;
        longint r;
        m = (s < 0) ? -s : s;
        r = (m + (longint'(1) << (k - 1))) >>> k;
        return (s < 0) ? -r : r;
    endfunction

    function automatic longint sat_pos(input longint v);
        longint hi;
        longint lo;
        hi = (longint'(1) << (POS_WIDTH - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

    // truncated square root, one result bit at a time
    function automatic longint floor_root(input longint n);
        longint r;
        longint c;
        r = 0;
        for (int b = 15; b >= 0; b--)
        begin
            c = r | (longint'(1) << b);
            if (c * c <= n)
                r = c;
        end
        return r;
    endfunction

    // damp by one half, add force, clamp to the speed limit
    function automatic longint damp_clamp(input longint v, input longint f);
        longint n;
        longint mag;
        n = half_away(2 * v + f, 2);
        mag = (n < 0) ? -n : n;
        if (mag >= limit_reg)
            n = (n < 0) ? -limit_reg : limit_reg;
        return n;
    endfunction

    // apply one accepted word to the particle and return the expected result
    function automatic ppas_result_t advance_particle(input ppas_item_t w);
        ppas_result_t r;
        longint dx;
        longint dy;
        longint fx;
        longint fy;
        longint d;
        if (w.func == FUNC_LOAD)
        begin
            particle_x     = sat_pos(longint'($signed(w.pos_x)));
            particle_y     = sat_pos(longint'($signed(w.pos_y)));
            particle_vx    = longint'($signed(w.vel_x));
            particle_vy    = longint'($signed(w.vel_y));
            particle_power = longint'($signed(w.power));
        end
        else
        begin
            dx = particle_x - longint'($signed(w.pos_x));
            dy = particle_y - longint'($signed(w.pos_y));
            fx = 0;
            fy = 0;
            if (dx > -32768 && dx < 32768 && dy > -32768 && dy < 32768)
            begin
                d = floor_root(dx * dx + dy * dy);
                if (d > 0 && d < radius_reg)
                begin
                    fx = (particle_power * dx) / (64 * d);
                    fy = (particle_power * dy) / (64 * d);
                end
            end
            particle_vx = damp_clamp(particle_vx, fx);
            particle_vy = damp_clamp(particle_vy, fy);
            particle_x  = sat_pos(particle_x + half_away(particle_vx, 8));
            particle_y  = sat_pos(particle_y + half_away(particle_vy, 8));
        end
        r.out_x    = data_t'(particle_x);
        r.out_y    = data_t'(particle_y);
        r.out_vx   = data_t'(particle_vx);
        r.out_vy   = data_t'(particle_vy);
        r.done_res = w.last_partner;
        return r;
    endfunction

    function automatic ppas_item_t make_word(input func_t f, input int px, input int py,
                                             input int vx, input int vy, input int pw,
                                             input bit last);
        ppas_item_t w;
        w.func         = f;
        w.pos_x        = data_t'(px);
        w.pos_y        = data_t'(py);
        w.vel_x        = data_t'(vx);
        w.vel_y        = data_t'(vy);
        w.power        = data_t'(pw);
        w.last_partner = last;
        return w;
    endfunction

    function automatic void check_field(input string name, input longint want,
                                        input longint got);
        if (want != got)
        begin
            if (mismatches < MAX_REPORTS)
                $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // result checker
    initial
    begin
        ppas_result_t want;
        forever
        begin
            @(posedge clk);
            if (result_ch.valid && result_ch.ready)
            begin
                if (expected_particles.size() == 0)
                begin
                    if (mismatches < MAX_REPORTS)
                        $error("result word with nothing expected: x %0d y %0d",
                               $signed(result_ch.out_x), $signed(result_ch.out_y));
                    mismatches++;
                end
                else
                begin
                    want = expected_particles.pop_front();
                    check_field("out_x", $signed(want.out_x), $signed(result_ch.out_x));
                    check_field("out_y", $signed(want.out_y), $signed(result_ch.out_y));
                    check_field("out_vx", $signed(want.out_vx), $signed(result_ch.out_vx));
                    check_field("out_vy", $signed(want.out_vy), $signed(result_ch.out_vy));
                    check_field("done_res", want.done_res, result_ch.done_res);
                end
            end
        end
    end

    // result side stalls
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            result_ch.ready <= no_idle || ($urandom_range(0, 99) >= 18);
        end
    end

    // send one word, with a random gap before it
    task automatic send_word(input ppas_item_t w);
        while (!no_idle && $urandom_range(0, 99) < 18)
        begin
            @(negedge clk);
            item_ch.valid <= 1'b0;
        end
        @(negedge clk);
        item_ch.valid        <= 1'b1;
        item_ch.func         <= w.func;
        item_ch.pos_x        <= w.pos_x;
        item_ch.pos_y        <= w.pos_y;
        item_ch.vel_x        <= w.vel_x;
        item_ch.vel_y        <= w.vel_y;
        item_ch.power        <= w.power;
        item_ch.last_partner <= w.last_partner;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        expected_particles.push_back(advance_particle(w));
    endtask

    // stop sending and wait until every result word is back
    task automatic settle_block();
        @(negedge clk);
        item_ch.valid <= 1'b0;
        while (expected_particles.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input cfg_val_t val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == REG_PULL_RANGE)
            radius_reg = longint'(val);
        else if (idx == REG_TOP_SPEED)
            limit_reg = longint'(val);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // field extremes, far partner, radius boundary, rounding halves
    task automatic test_load_and_edges();
        // interact straight out of reset, partner on the particle
        send_word(make_word(FUNC_INTERACT, 0, 0, 0, 0, 0, 1'b0));
        // extreme load, then a partner too far away on both axes
        send_word(make_word(FUNC_LOAD, 32767, -32768, 32767, -32768, -32768, 1'b0));
        send_word(make_word(FUNC_INTERACT, -32768, 32767, -1, -1, -1, 1'b1));
        // near partners around the default radius of 80
        send_word(make_word(FUNC_LOAD, 0, 0, 0, 0, 32767, 1'b1));
        send_word(make_word(FUNC_INTERACT, 3, 4, 0, 0, 0, 1'b0));
        send_word(make_word(FUNC_INTERACT, 0, 0, 0, 0, 0, 1'b0));
        send_word(make_word(FUNC_INTERACT, 80, 0, 0, 0, 0, 1'b0));
        send_word(make_word(FUNC_INTERACT, 0, -79, 0, 0, 0, 1'b1));
        // most negative power at distance one
        send_word(make_word(FUNC_LOAD, -5, 7, 100, -100, -32768, 1'b0));
        send_word(make_word(FUNC_INTERACT, -4, 8, 0, 0, 0, 1'b1));
        // velocity and position rounding of halves, both signs
        send_word(make_word(FUNC_LOAD, 10, -10, 2, -2, 0, 1'b0));
        send_word(make_word(FUNC_INTERACT, 10, -10, 0, 0, 0, 1'b0));
        send_word(make_word(FUNC_LOAD, 10, -10, 1, -1, 0, 1'b0));
        send_word(make_word(FUNC_INTERACT, 10, -10, 0, 0, 0, 1'b0));
        send_word(make_word(FUNC_LOAD, 10, -10, 256, -256, 0, 1'b0));
        send_word(make_word(FUNC_INTERACT, 10, -10, 0, 0, 0, 1'b1));
        settle_block();
    endtask

    // a zero radius never lets a partner pull
    task automatic test_zero_radius();
        write_reg(REG_PULL_RANGE, '0);
        send_word(make_word(FUNC_LOAD, 100, 100, 300, -300, 32767, 1'b0));
        send_word(make_word(FUNC_INTERACT, 101, 100, 0, 0, 0, 1'b0));
        send_word(make_word(FUNC_INTERACT, 97, 104, 0, 0, 0, 1'b1));
        settle_block();
    endtask

    // a zero limit forces every velocity to zero
    task automatic test_zero_limit();
        write_reg(REG_PULL_RANGE, 15'h7FFF);
        write_reg(REG_TOP_SPEED, '0);
        send_word(make_word(FUNC_LOAD, -300, 200, 32767, -32768, 32767, 1'b1));
        send_word(make_word(FUNC_INTERACT, 300, -200, 0, 0, 0, 1'b0));
        send_word(make_word(FUNC_INTERACT, -300, 200, 0, 0, 0, 1'b1));
        settle_block();
    endtask

    // random particle groups under one register setting
    task automatic run_groups(input cfg_val_t radius, input cfg_val_t limit,
                              input int words, input bit calm, input bit pause_midway);
        int sent;
        int members;
        int span;
        int px;
        int py;
        int vx;
        int vy;
        bit paused;
        write_reg(REG_PULL_RANGE, radius);
        write_reg(REG_TOP_SPEED, limit);
        no_idle = calm;
        span = (radius < 400) ? int'(radius) + 3 : 400;
        sent = 0;
        paused = 1'b0;
        while (sent < words)
        begin
            // load word, sometimes parked near the edge of the field
            if ($urandom_range(0, 99) < 15)
            begin
                px = $urandom_range(0, 1) ? 32767 - int'($urandom_range(0, 40))
                                          : -32768 + int'($urandom_range(0, 40));
                py = $urandom_range(0, 1) ? 32767 - int'($urandom_range(0, 40))
                                          : -32768 + int'($urandom_range(0, 40));
            end
            else
            begin
                px = int'($urandom);
                py = int'($urandom);
            end
            if ($urandom_range(0, 1))
            begin
                vx = int'($urandom);
                vy = int'($urandom);
            end
            else
            begin
                vx = int'($urandom_range(0, 4000)) - 2000;
                vy = int'($urandom_range(0, 4000)) - 2000;
            end
            send_word(make_word(FUNC_LOAD, px, py, vx, vy, int'($urandom),
                                1'($urandom_range(0, 1))));
            sent++;
            // partner words, mostly near the particle
            members = $urandom_range(1, 12);
            for (int i = 0; i < members; i++)
            begin
                if ($urandom_range(0, 99) < 80)
                begin
                    px = int'(particle_x) + int'($urandom_range(0, 2 * span)) - span;
                    py = int'(particle_y) + int'($urandom_range(0, 2 * span)) - span;
                end
                else
                begin
                    px = int'($urandom);
                    py = int'($urandom);
                end
                send_word(make_word(FUNC_INTERACT, px, py, int'($urandom), int'($urandom),
                                    int'($urandom),
                                    (i == members - 1) || ($urandom_range(0, 19) == 0)));
                sent++;
            end
            // hold the sender until the block has caught up
            if (pause_midway && !paused && sent >= words / 2)
            begin
                settle_block();
                paused = 1'b1;
            end
        end
        settle_block();
        no_idle = 1'b0;
    endtask

    task automatic test_random_groups();
        run_groups(PULL_RANGE_RST, TOP_SPEED_RST, 80, 1'b0, 1'b1);
        run_groups(15'h7FFF, 15'h7FFF, 80, 1'b1, 1'b0);
        run_groups(15'd1, 15'd0, 80, 1'b0, 1'b0);
        run_groups(15'd200, 15'd4000, 80, 1'b0, 1'b0);
        run_groups(15'd40, 15'd256, 80, 1'b0, 1'b0);
    endtask

    // reset, tests in turn, final verdict
    initial
    begin
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = '0;
        cfg_data             = '0;
        item_ch.valid        = 1'b0;
        item_ch.func         = FUNC_LOAD;
        item_ch.pos_x        = '0;
        item_ch.pos_y        = '0;
        item_ch.vel_x        = '0;
        item_ch.vel_y        = '0;
        item_ch.power        = '0;
        item_ch.last_partner = 1'b0;
        no_idle              = 1'b0;
        mismatches           = 0;
        particle_x           = 0;
        particle_y           = 0;
        particle_vx          = 0;
        particle_vy          = 0;
        particle_power       = 0;
        radius_reg           = longint'(PULL_RANGE_RST);
        limit_reg            = longint'(TOP_SPEED_RST);
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_load_and_edges();
        test_zero_radius();
        test_zero_limit();
        test_random_groups();

        settle_block();
        repeat (50) @(posedge clk);
        if (mismatches == 0 && expected_particles.size() == 0)
            $display("tb_particle_pair_attraction_step: done, clean");
        else
            $display("tb_particle_pair_attraction_step: done, errors");
        $finish;
    end

endmodule
